// ===== design/its_pkg.sv =====
// Package for the integer-to-text converter: widths, character codes,
// the classification struct passed through the queue and the digit encoder.
// No dependencies.
package its_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int RADIX_W        = 6;
  localparam int CHAR_W         = 8;
  localparam int DIGIT_STEPS    = 8;   // quotient bits resolved per cycle

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOW_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

  // Per-item classification from the front end
  typedef struct packed {
    logic               neg;
    logic               bad;
    logic [RADIX_W-1:0] radix;
  } its_cls_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_TEN) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_LOW_A + CHAR_W'(d - DIGIT_TEN);
    end
    return c;
  endfunction

endpackage

// ===== design/its_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module its_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/its_queue.sv =====
// Two-entry queue between the front end and the conversion engine.
// No dependencies.
module its_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = slot_q[rptr_q];

  always_comb begin
    wptr_d = do_wr ? !wptr_q : wptr_q;
    rptr_d = do_rd ? !rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(do_wr) - 2'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== design/its_front.sv =====
// Front end: holds the radix register, takes numbers in and classifies them
// (sign, magnitude, radix validity). Depends on its_pkg.
module its_front #(
  parameter int VALUE_BITS = its_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [its_pkg::RADIX_W-1:0] cfg_wdata_i,
  input  logic                        push,
  input  logic                        q_full_i,
  input  logic [VALUE_BITS-1:0]       number_i,
  output logic                        q_wr_o,
  output its_pkg::its_cls_t           cls_o,
  output logic [VALUE_BITS-1:0]       mag_o
);

  logic [its_pkg::RADIX_W-1:0] radix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= its_pkg::RADIX_RESET;
    end else if (cfg_we_i) begin
      radix_q <= cfg_wdata_i;
    end
  end

  assign q_wr_o    = push && !q_full_i;
  assign cls_o.neg = number_i[VALUE_BITS-1];
  assign cls_o.bad = (radix_q < its_pkg::RADIX_MIN) || (radix_q > its_pkg::RADIX_MAX);
  assign cls_o.radix = radix_q;
  // most negative value maps onto itself, read as unsigned it is exact
  assign mag_o = number_i[VALUE_BITS-1] ? (~number_i + 1'b1) : number_i;

endmodule

// ===== design/its_back.sv =====
// Conversion engine: repeated division by the radix (eight quotient bits a
// cycle), digits stored in a small RAM, then emitted most significant first
// through a one-beat output register. Depends on its_pkg and its_ram.
module its_back #(
  parameter int VALUE_BITS = its_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  its_pkg::its_cls_t           cls_i,
  input  logic [VALUE_BITS-1:0]       mag_i,
  output logic                        q_rd_o,
  output logic                        empty,
  input  logic                        pop,
  output logic [its_pkg::CHAR_W-1:0]  char_code_o,
  output logic                        last_char_o,
  output logic                        empty_res_o
);

  localparam int STEPS = its_pkg::DIGIT_STEPS;
  localparam int PW    = ((VALUE_BITS + STEPS - 1) / STEPS) * STEPS;
  localparam int NCYC  = PW / STEPS;
  localparam int CYC_W = $clog2(NCYC + 1);
  localparam int DEPTH = VALUE_BITS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = its_pkg::RADIX_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_SIGN, S_RD, S_LOAD, S_INVAL
  } state_e;

  state_e                     state_q;
  logic [PW-1:0]              quo_q, quo_n;
  logic [RW-1:0]              rem_q, rem_n;
  logic [RW:0]                trial;
  logic [CYC_W-1:0]           cyc_q;
  logic [AW-1:0]              wa_q;
  logic [AW-1:0]              idx_q;
  logic                       neg_q;
  logic [RW-1:0]              radix_q;
  logic                       out_valid_q;
  logic [its_pkg::CHAR_W-1:0] char_q;
  logic                       last_q;
  logic                       empres_q;
  logic                       slot_free;
  logic                       digit_done;
  logic                       ram_we;
  logic                       ram_re;
  logic [RW-1:0]              ram_rdata;

  // one radix digit of the quotient: restoring division, STEPS bits a cycle
  always_comb begin
    quo_n = quo_q;
    rem_n = rem_q;
    trial = '0;
    for (int k = 0; k < STEPS; k++) begin
      trial = {rem_n, quo_n[PW-1]};
      quo_n = {quo_n[PW-2:0], 1'b0};
      if (trial >= {1'b0, radix_q}) begin
        trial    = trial - {1'b0, radix_q};
        quo_n[0] = 1'b1;
      end
      rem_n = trial[RW-1:0];
    end
  end

  assign digit_done = (state_q == S_DIV) && (cyc_q == CYC_W'(NCYC - 1));
  assign ram_we     = digit_done;
  assign ram_re     = (state_q == S_RD);
  assign slot_free  = !out_valid_q || pop;
  assign q_rd_o     = (state_q == S_IDLE) && !q_empty_i;

  its_ram #(
    .WIDTH (RW),
    .DEPTH (DEPTH)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wa_q),
    .wdata_i (rem_n),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      cyc_q       <= '0;
      wa_q        <= '0;
      idx_q       <= '0;
      neg_q       <= 1'b0;
      radix_q     <= its_pkg::RADIX_RESET;
      quo_q       <= '0;
      rem_q       <= '0;
      char_q      <= its_pkg::CHAR_NONE;
      last_q      <= 1'b0;
      empres_q    <= 1'b0;
    end else begin
      // drop the beat once it is taken; loads below override
      if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            neg_q   <= cls_i.neg;
            radix_q <= cls_i.radix;
            quo_q   <= PW'(mag_i);
            rem_q   <= '0;
            cyc_q   <= '0;
            wa_q    <= '0;
            state_q <= cls_i.bad ? S_INVAL : S_DIV;
          end
        end
        S_DIV: begin
          if (digit_done) begin
            quo_q <= quo_n;
            rem_q <= '0;
            cyc_q <= '0;
            if (quo_n == '0) begin
              idx_q   <= wa_q;
              state_q <= S_SIGN;
            end else begin
              wa_q <= wa_q + 1'b1;
            end
          end else begin
            quo_q <= quo_n;
            rem_q <= rem_n;
            cyc_q <= cyc_q + 1'b1;
          end
        end
        S_SIGN: begin
          if (!neg_q) begin
            state_q <= S_RD;
          end else if (slot_free) begin
            out_valid_q <= 1'b1;
            char_q      <= its_pkg::CHAR_MINUS;
            last_q      <= 1'b0;
            empres_q    <= 1'b0;
            state_q     <= S_RD;
          end
        end
        S_RD: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            char_q      <= its_pkg::digit_char(ram_rdata);
            last_q      <= (idx_q == '0);
            empres_q    <= 1'b0;
            if (idx_q == '0) begin
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q - 1'b1;
              state_q <= S_RD;
            end
          end
        end
        S_INVAL: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            char_q      <= its_pkg::CHAR_NONE;
            last_q      <= 1'b1;
            empres_q    <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign empty       = !out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;
  assign empty_res_o = empres_q;

endmodule

// ===== design/int_to_radix_string_top.sv =====
// Integer-to-text converter, top level. The engine divides each digit out of the
// magnitude in S_DIV, emits a leading minus for negative numbers in S_SIGN, then
// reads each digit from the RAM (S_RD) and loads it into the output register
// (S_LOAD), waiting while the held character is not yet popped. A two-entry queue
// takes numbers meanwhile. Reset sets the radix to 10 and empties queue and output;
// digit RAM is not cleared.
module int_to_radix_string_top #(
  parameter int VALUE_BITS = its_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [its_pkg::RADIX_W-1:0] cfg_wdata_i,
  input  logic                        push,
  output logic                        full,
  input  logic [VALUE_BITS-1:0]       number_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [its_pkg::CHAR_W-1:0]  char_code_o,
  output logic                        last_char_o,
  output logic                        empty_res_o
);

  localparam int CLS_W = $bits(its_pkg::its_cls_t);
  localparam int QW    = CLS_W + VALUE_BITS;

  logic                    q_wr, q_rd, q_empty;
  its_pkg::its_cls_t       cls_in, cls_out;
  logic [VALUE_BITS-1:0]   mag_in, mag_out;
  logic [QW-1:0]           q_rdata;

  its_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .q_full_i    (full),
    .number_i    (number_i),
    .q_wr_o      (q_wr),
    .cls_o       (cls_in),
    .mag_o       (mag_in)
  );

  its_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i ({cls_in, mag_in}),
    .full_o  (full),
    .rd_i    (q_rd),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign cls_out = q_rdata[QW-1:VALUE_BITS];
  assign mag_out = q_rdata[VALUE_BITS-1:0];

  its_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .cls_i       (cls_out),
    .mag_i       (mag_out),
    .q_rd_o      (q_rd),
    .empty       (empty),
    .pop         (pop),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o),
    .empty_res_o (empty_res_o)
  );

  // empty result carries no character and closes its string
  a_empty_res_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && empty_res_o) |-> (last_char_o && char_code_o == its_pkg::CHAR_NONE))
    else $error("empty result malformed");

  // a minus sign is never the final character
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && char_code_o == its_pkg::CHAR_MINUS) |-> !last_char_o)
    else $error("minus sign closes a string");

  // characters are digits, lowercase letters or the minus sign
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !empty_res_o) |->
      ((char_code_o >= its_pkg::CHAR_ZERO && char_code_o <= its_pkg::CHAR_NINE) ||
       (char_code_o >= its_pkg::CHAR_LOW_A && char_code_o <= its_pkg::CHAR_LOW_Z) ||
       (char_code_o == its_pkg::CHAR_MINUS)))
    else $error("character outside the digit set");

  // the engine only draws from the queue when it holds an entry
  a_queue_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd |-> !q_empty)
    else $error("queue read while empty");

endmodule
